FILE: rtl/ouv_pkg.sv
// Package for the orthogonal unit vector block: widths, pipeline depths and word types.
// Used by every module in the rtl folder; depends on nothing else.
package ouv_pkg;

    localparam int COMP_W       = 32;
    localparam int MAG_W        = 32;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int FRAC_BITS    = 60;
    localparam int QUOT_W       = FRAC_BITS + 1;
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int SQRT_STEPS   = FRAC_BITS / 2 + 1;
    localparam int ROOT_W       = SQRT_STEPS;
    localparam int RAD_W        = FRAC_BITS + 2;
    localparam int PROD_W       = 2 * ROOT_W;
    localparam int UNIT_SHIFT   = FRAC_BITS / 2;
    localparam int FRONT_STAGES = 4;
    localparam int SIDE_DEPTH   = DIV_STEPS + SQRT_STEPS;
    localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + SQRT_STEPS + 2;

    localparam logic signed [COMP_W-1:0] UNIT_ONE = COMP_W'(1) <<< UNIT_SHIFT;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic signed [COMP_W-1:0] ref_x;
        logic signed [COMP_W-1:0] ref_y;
        logic signed [COMP_W-1:0] ref_z;
    } t_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic                     zero_input;
    } t_out;

    // Operands handed from the front end to the dividers.
    typedef struct packed {
        logic [SQ_W-1:0] s;
        logic [SQ_W-1:0] t;
        logic [SQ_W-1:0] sq_k;
        logic [SQ_W-1:0] sq_j1;
        logic [SQ_W-1:0] sq_j2;
    } t_front;

    // Control that rides alongside the arithmetic pipelines.
    typedef struct packed {
        logic  valid;
        t_axis axis;
        logic  neg_k;
        logic  neg_j1;
        logic  neg_j2;
        logic  zero;
    } t_side;

endpackage

FILE: rtl/ouv_div.sv
// Pipelined restoring divider: floor(num * 2^60 / den) for num <= den, one quotient bit a stage.
// Depends on ouv_pkg.
module ouv_div (
    input  logic                        i_clk,
    input  logic [ouv_pkg::SQ_W-1:0]    i_num,
    input  logic [ouv_pkg::SQ_W-1:0]    i_den,
    output logic [ouv_pkg::QUOT_W-1:0]  o_quot
);
    import ouv_pkg::*;

    logic [SQ_W-1:0]   r_rem  [DIV_STEPS-1];
    logic [SQ_W-1:0]   r_den  [DIV_STEPS-1];
    logic [QUOT_W-1:0] r_quot [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [SQ_W:0]     wide;
        logic [SQ_W-1:0]   den_in;
        logic [QUOT_W-1:0] quot_in;
        logic [SQ_W+1:0]   diff;
        logic              ge;
        logic [QUOT_W-1:0] n_quot;

        // The first step compares the numerator itself; later ones shift the remainder.
        if (g == 0) begin : g_head
            assign wide    = {1'b0, i_num};
            assign den_in  = i_den;
            assign quot_in = '0;
        end else begin : g_body
            assign wide    = {r_rem[g-1], 1'b0};
            assign den_in  = r_den[g-1];
            assign quot_in = r_quot[g-1];
        end

        assign diff   = {1'b0, wide} - {2'b00, den_in};
        assign ge     = ~diff[SQ_W+1];
        assign n_quot = {quot_in[QUOT_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            r_quot[g] <= n_quot;
        end

        if (g < DIV_STEPS - 1) begin : g_pass
            logic [SQ_W-1:0] n_rem;
            assign n_rem = ge ? diff[SQ_W-1:0] : wide[SQ_W-1:0];
            always_ff @(posedge i_clk) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
            end
        end
    end

    assign o_quot = r_quot[DIV_STEPS-1];

endmodule

FILE: rtl/ouv_sqrt.sv
// Pipelined integer square root of a value up to 2^60, one result bit a stage.
// Depends on ouv_pkg.
module ouv_sqrt (
    input  logic                        i_clk,
    input  logic [ouv_pkg::QUOT_W-1:0]  i_rad,
    output logic [ouv_pkg::ROOT_W-1:0]  o_root
);
    import ouv_pkg::*;

    logic [RAD_W-1:0] r_rad [SQRT_STEPS-1];
    logic [RAD_W-1:0] r_res [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - g));
        logic [RAD_W-1:0] rad_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] trial;
        logic             ge;
        logic [RAD_W-1:0] n_res;

        if (g == 0) begin : g_head
            assign rad_in = RAD_W'(i_rad);
            assign res_in = '0;
        end else begin : g_body
            assign rad_in = r_rad[g-1];
            assign res_in = r_res[g-1];
        end

        assign trial = res_in + STEP_BIT;
        assign ge    = (rad_in >= trial);
        assign n_res = ge ? ((res_in >> 1) + STEP_BIT) : (res_in >> 1);

        always_ff @(posedge i_clk) begin
            r_res[g] <= n_res;
        end

        if (g < SQRT_STEPS - 1) begin : g_pass
            logic [RAD_W-1:0] n_rad;
            assign n_rad = ge ? (rad_in - trial) : rad_in;
            always_ff @(posedge i_clk) begin
                r_rad[g] <= n_rad;
            end
        end
    end

    assign o_root = r_res[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

FILE: rtl/ouv_front.sv
// Front end: magnitudes, squares, axis choice, sum of squares and remainder sum.
// Four register stages; depends on ouv_pkg.
module ouv_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ouv_pkg::t_in    i_ref,
    output ouv_pkg::t_front o_data,
    output ouv_pkg::t_side  o_side
);
    import ouv_pkg::*;

    logic [COMP_W-1:0] raw [3];
    logic [MAG_W-1:0]  n_mag [3];

    logic              r_v1;
    logic [MAG_W-1:0]  r_mag [3];
    logic [2:0]        r_neg1;

    t_axis             n_k;
    logic [SQ_W-1:0]   n_sq [3];
    logic              r_v2;
    logic [SQ_W-1:0]   r_sq [3];
    t_axis             r_k2;
    logic [2:0]        r_neg2;

    logic [SQ_W-1:0]   n_sqk, n_sqj1, n_sqj2;
    logic              n_negk, n_negj1, n_negj2;
    logic              r_v3;
    logic [SQ_W-1:0]   r_s, r_sqk, r_sqj1, r_sqj2;
    t_axis             r_k3;
    logic              r_negk, r_negj1, r_negj2;

    t_front            r_data;
    t_side             r_side;

    assign raw[0] = i_ref.ref_x;
    assign raw[1] = i_ref.ref_y;
    assign raw[2] = i_ref.ref_z;

    // The most negative value keeps magnitude 2^31 in an unsigned 32-bit word.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = raw[i][COMP_W-1] ? (~raw[i] + MAG_W'(1)) : raw[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = SQ_W'(r_mag[i]) * SQ_W'(r_mag[i]);
        end
    end

    // Smallest magnitude wins; a tie keeps the earlier axis.
    always_comb begin
        n_k = AXIS_X;
        if (r_mag[1] < r_mag[0]) begin
            n_k = AXIS_Y;
        end
        if (r_mag[2] < ((n_k == AXIS_Y) ? r_mag[1] : r_mag[0])) begin
            n_k = AXIS_Z;
        end
    end

    always_comb begin
        unique case (r_k2)
            AXIS_Y: begin
                n_sqk = r_sq[1]; n_sqj1 = r_sq[0]; n_sqj2 = r_sq[2];
                n_negk = r_neg2[1]; n_negj1 = r_neg2[0]; n_negj2 = r_neg2[2];
            end
            AXIS_Z: begin
                n_sqk = r_sq[2]; n_sqj1 = r_sq[0]; n_sqj2 = r_sq[1];
                n_negk = r_neg2[2]; n_negj1 = r_neg2[0]; n_negj2 = r_neg2[1];
            end
            default: begin
                n_sqk = r_sq[0]; n_sqj1 = r_sq[1]; n_sqj2 = r_sq[2];
                n_negk = r_neg2[0]; n_negj1 = r_neg2[1]; n_negj2 = r_neg2[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_side <= '0;
        end else begin
            r_v1         <= i_valid;
            r_v2         <= r_v1;
            r_v3         <= r_v2;
            r_side.valid <= r_v3;
            r_side.axis  <= r_k3;
            r_side.neg_k  <= r_negk;
            r_side.neg_j1 <= r_negj1;
            r_side.neg_j2 <= r_negj2;
            r_side.zero   <= (r_s == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mag[i]  <= n_mag[i];
            r_neg1[i] <= raw[i][COMP_W-1];
            r_sq[i]   <= n_sq[i];
        end
        r_k2    <= n_k;
        r_neg2  <= r_neg1;
        r_s     <= r_sq[0] + r_sq[1] + r_sq[2];
        r_sqk   <= n_sqk;
        r_sqj1  <= n_sqj1;
        r_sqj2  <= n_sqj2;
        r_k3    <= r_k2;
        r_negk  <= n_negk;
        r_negj1 <= n_negj1;
        r_negj2 <= n_negj2;
        r_data.s     <= r_s;
        r_data.t     <= r_s - r_sqk;
        r_data.sq_k  <= r_sqk;
        r_data.sq_j1 <= r_sqj1;
        r_data.sq_j2 <= r_sqj2;
    end

    assign o_data = r_data;
    assign o_side = r_side;

endmodule

FILE: rtl/orthogonal_unit_vector_3d.sv
// Throughput: one word per cycle; busy is always low and a new word may enter every cycle.
// The depth is set by the 61-stage fraction dividers and the 31-stage square roots.
// The receiver cannot stall; o_valid marks each result for exactly one cycle.
// Reset clears the valid bits of every stage; data registers are not reset.
// Depends on ouv_pkg, ouv_front, ouv_div and ouv_sqrt.
module orthogonal_unit_vector_3d (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ouv_pkg::t_in  i_ref,
    output ouv_pkg::t_out o_res,
    output logic          o_valid
);
    import ouv_pkg::*;

    // The pipeline never refuses a word, so accept is simply start.
    logic              accept;
    t_front            front_data;
    t_side             front_side;

    // Fraction quotients: A^2 = r_k^2/S, U^2 = T/S, B_j^2 = r_j^2/T, all in 2^60 units.
    logic [QUOT_W-1:0] quot_a, quot_u, quot_b1, quot_b2;
    logic [ROOT_W-1:0] root_a, root_u, root_b1, root_b2;

    t_side             r_side [SIDE_DEPTH];
    t_side             r_side_m;
    logic [PROD_W-1:0] r_prod1, r_prod2;
    logic [ROOT_W-1:0] r_root_k;

    logic [COMP_W-1:0] mag1, mag2, val1, val2, val_k;
    t_out              n_out;
    t_out              r_out;
    logic              r_valid;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    ouv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_ref   (i_ref),
        .o_data  (front_data),
        .o_side  (front_side)
    );

    ouv_div u_div_a  (.i_clk(i_clk), .i_num(front_data.sq_k),  .i_den(front_data.s),
                      .o_quot(quot_a));
    ouv_div u_div_u  (.i_clk(i_clk), .i_num(front_data.t),     .i_den(front_data.s),
                      .o_quot(quot_u));
    ouv_div u_div_b1 (.i_clk(i_clk), .i_num(front_data.sq_j1), .i_den(front_data.t),
                      .o_quot(quot_b1));
    ouv_div u_div_b2 (.i_clk(i_clk), .i_num(front_data.sq_j2), .i_den(front_data.t),
                      .o_quot(quot_b2));

    ouv_sqrt u_sqrt_a  (.i_clk(i_clk), .i_rad(quot_a),  .o_root(root_a));
    ouv_sqrt u_sqrt_u  (.i_clk(i_clk), .i_rad(quot_u),  .o_root(root_u));
    ouv_sqrt u_sqrt_b1 (.i_clk(i_clk), .i_rad(quot_b1), .o_root(root_b1));
    ouv_sqrt u_sqrt_b2 (.i_clk(i_clk), .i_rad(quot_b2), .o_root(root_b2));

    // The control word follows the divider and root pipelines in lockstep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIDE_DEPTH; i++) begin
                r_side[i] <= '0;
            end
            r_side_m <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_side[0] <= front_side;
            for (int i = 1; i < SIDE_DEPTH; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_side_m <= r_side[SIDE_DEPTH-1];
            r_valid  <= r_side_m.valid;
        end
    end

    // The off-axis components are A * B_j, scaled back to Q2.30.
    always_ff @(posedge i_clk) begin
        r_prod1  <= PROD_W'(root_a) * PROD_W'(root_b1);
        r_prod2  <= PROD_W'(root_a) * PROD_W'(root_b2);
        r_root_k <= root_u;
    end

    // An off-axis component is negative when r_k and r_j carry the same sign.
    assign mag1  = r_prod1[PROD_W-1:UNIT_SHIFT];
    assign mag2  = r_prod2[PROD_W-1:UNIT_SHIFT];
    assign val1  = (r_side_m.neg_k == r_side_m.neg_j1) ? (~mag1 + COMP_W'(1)) : mag1;
    assign val2  = (r_side_m.neg_k == r_side_m.neg_j2) ? (~mag2 + COMP_W'(1)) : mag2;
    assign val_k = COMP_W'(r_root_k);

    always_comb begin
        n_out = '0;
        unique case (r_side_m.axis)
            AXIS_X: begin
                n_out.unit_x = val_k; n_out.unit_y = val1;  n_out.unit_z = val2;
            end
            AXIS_Y: begin
                n_out.unit_x = val1;  n_out.unit_y = val_k; n_out.unit_z = val2;
            end
            AXIS_Z: begin
                n_out.unit_x = val1;  n_out.unit_y = val2;  n_out.unit_z = val_k;
            end
            default: begin
                n_out = '0;
            end
        endcase
        // A zero reference vector has no direction: all components are forced to zero.
        if (r_side_m.zero) begin
            n_out            = '0;
            n_out.zero_input = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res   = r_out;
    assign o_valid = r_valid;

`ifndef SYNTHESIS
    a_zero_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.zero_input |->
            o_res.unit_x == '0 && o_res.unit_y == '0 && o_res.unit_z == '0)
        else $error("zero reference vector gave a nonzero component");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result strobe without a word accepted at the pipeline latency");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.zero_input |->
            o_res.unit_x <= UNIT_ONE && o_res.unit_x >= -UNIT_ONE &&
            o_res.unit_y <= UNIT_ONE && o_res.unit_y >= -UNIT_ONE &&
            o_res.unit_z <= UNIT_ONE && o_res.unit_z >= -UNIT_ONE)
        else $error("unit vector component outside the range of one");
`endif

endmodule

FILE: test/orthogonal_unit_vector_3d_tb.sv
`timescale 1ns / 1ps
// Testbench for orthogonal_unit_vector_3d: drives reference vectors and checks each unit vector.
// Depends on ouv_pkg and the RTL top level; predicts results with exact integer arithmetic.
module orthogonal_unit_vector_3d_tb;
    import ouv_pkg::*;

    localparam int LAT_CYCLES = 98;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_in   i_ref;
    t_out  o_res;
    logic  o_valid;

    t_out  expected_units[$];
    int    mismatches;
    int    words_sent;
    int    results_seen;
    int    zero_words;
    bit    timed_out;

    orthogonal_unit_vector_3d i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_ref   (i_ref),
        .o_res   (o_res),
        .o_valid (o_valid)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Floor of num * 2^60 / den, for num <= den, by a wide integer division.
    function automatic logic [63:0] frac_q60(logic [63:0] num, logic [63:0] den);
        logic [127:0] wide;
        begin
            if (den == 64'd0) return 64'd0;
            wide = {64'd0, num} << 60;
            return 64'(wide / {64'd0, den});
        end
    endfunction

    // Floor square root, bit by bit from the top.
    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0]  root;
        logic [127:0] trial;
        begin
            root = 64'd0;
            for (int b = 31; b >= 0; b--) begin
                trial = (root | (64'd1 << b)) * (root | (64'd1 << b));
                if (trial <= {64'd0, v}) root = root | (64'd1 << b);
            end
            return root;
        end
    endfunction

    // Gram-Schmidt of the smallest axis against the reference vector, in Q2.30.
    function automatic t_out perpendicular_unit(t_in r);
        logic [31:0] comp[3];
        logic [31:0] mag[3];
        logic        neg[3];
        logic [63:0] sq[3];
        logic [63:0] unit[3];
        logic [63:0] sum_sq, rest_sq, a_root, b_root, prod;
        t_axis       axis;
        t_out        res;
        begin
            comp[0] = r.ref_x;
            comp[1] = r.ref_y;
            comp[2] = r.ref_z;
            for (int i = 0; i < 3; i++) begin
                neg[i] = comp[i][31];
                mag[i] = neg[i] ? -comp[i] : comp[i];
                sq[i]  = 64'(mag[i]) * 64'(mag[i]);
            end
            sum_sq = sq[0] + sq[1] + sq[2];
            res = '0;
            if (sum_sq == 64'd0) begin
                res.zero_input = 1'b1;
                return res;
            end
            // Ties go to the earlier axis.
            axis = AXIS_X;
            if (mag[1] < mag[axis]) axis = AXIS_Y;
            if (mag[2] < mag[axis]) axis = AXIS_Z;
            rest_sq = sum_sq - sq[axis];
            a_root = floor_sqrt(frac_q60(sq[axis], sum_sq));
            unit[axis] = floor_sqrt(frac_q60(rest_sq, sum_sq));
            for (int i = 0; i < 3; i++) begin
                if (i != int'(axis)) begin
                    b_root = floor_sqrt(frac_q60(sq[i], rest_sq));
                    prod = (a_root * b_root) >> 30;
                    if (prod != 64'd0 && neg[axis] == neg[i]) prod = -prod;
                    unit[i] = prod;
                end
            end
            res.unit_x = unit[0][31:0];
            res.unit_y = unit[1][31:0];
            res.unit_z = unit[2][31:0];
            return res;
        end
    endfunction

    // Sends one word: start rises at an edge and holds until an edge with busy low.
    task automatic send_word(t_in r);
        begin
            start <= 1'b1;
            i_ref <= r;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            expected_units.push_back(perpendicular_unit(r));
            words_sent++;
            if (r == '0) zero_words++;
        end
    endtask

    task automatic go_idle(int cycles);
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Compares each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_units.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", o_res);
            end else begin
                want = expected_units.pop_front();
                if (o_res.unit_x !== want.unit_x || o_res.unit_y !== want.unit_y ||
                    o_res.unit_z !== want.unit_z || o_res.zero_input !== want.zero_input) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h z=%h zero=%b, got x=%h y=%h z=%h zero=%b",
                                 want.unit_x, want.unit_y, want.unit_z, want.zero_input,
                                 o_res.unit_x, o_res.unit_y, o_res.unit_z, o_res.zero_input);
                end
            end
        end
    end

    function automatic t_in make_ref(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in r;
        begin
            r.ref_x = x;
            r.ref_y = y;
            r.ref_z = z;
            return r;
        end
    endfunction

    function automatic logic [31:0] random_comp();
        begin
            case ($urandom_range(0, 5))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'(int'($urandom_range(0, 8)) - 4);
                3: return 32'($signed($urandom) >>> $urandom_range(0, 31));
                default: return $urandom;
            endcase
        end
    endfunction

    // Zero vector, axis extremes, every tie order and the most negative component.
    task automatic test_directed();
        logic [31:0] vals[6];
        begin
            vals = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h1, 32'h0001_0000};
            send_word(make_ref(0, 0, 0));
            send_word(make_ref(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
            send_word(make_ref(32'hffff_0000, 32'h0001_0000, 32'hffff_0000));
            send_word(make_ref(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
            send_word(make_ref(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
            send_word(make_ref(32'h5, 32'h3, 32'h3));
            send_word(make_ref(32'h5, 32'h7, 32'hffff_fffd));
            send_word(make_ref(32'hffff_ffff, 32'h0, 32'h0));
            send_word(make_ref(32'h0, 32'h0, 32'h8000_0000));
            send_word(make_ref(32'h0, 32'h7fff_ffff, 32'h0));
            for (int i = 0; i < 6; i++)
                send_word(make_ref(vals[i], vals[(i + 2) % 6], vals[(i + 4) % 6]));
            send_word(make_ref(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
            send_word(make_ref(32'haaaa_aaaa, 32'h5555_5555, 32'h1234_5678));
            go_idle(1);
        end
    endtask

    // Random vectors in bursts with random gaps, some stretches back to back.
    task automatic test_random(int count);
        int burst;
        begin
            while (count > 0) begin
                burst = $urandom_range(1, 40);
                for (int i = 0; i < burst && count > 0; i++, count--)
                    send_word(make_ref(random_comp(), random_comp(), random_comp()));
                if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 12));
            end
            go_idle(1);
        end
    endtask

    initial begin
        start = 1'b0;
        i_ref = '0;
        i_rst_n = 1'b0;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        zero_words = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(2000);
        while (expected_units.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (LAT_CYCLES + 10) @(posedge i_clk);
        $display("Sent %0d vectors (%0d zero), checked %0d results, %0d mismatches.",
                 words_sent, zero_words, results_seen, mismatches);
        if (mismatches == 0 && expected_units.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        timed_out = 1'b0;
        #2_000_000;
        timed_out = 1'b1;
        $display("Run timed out with %0d results outstanding.", expected_units.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
